FILE: rtl/core/pbp_pkg.sv
// Shared constants and types of the MSB-first bit packer.
`default_nettype none
package pbp_pkg;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int PEND_W  = 7;
    localparam int PCNT_W  = 3;
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;
endpackage
`default_nettype wire

FILE: rtl/core/pbp_front.sv
// Front end: accepts codes, joins them to the pending bits and queues aligned bytes.
`default_nettype none
module pbp_front #(
    parameter int MAX_CODE_BITS = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire [pbp_pkg::CODE_W-1:0] i_code_value,
    input  wire [pbp_pkg::LEN_W-1:0]  i_code_length,
    input  wire                       i_flush,
    input  wire pbp_pkg::t_q_stat     i_q_stat,
    output logic                      o_push,
    output logic [8*(((pbp_pkg::PEND_W + MAX_CODE_BITS) + 7) / 8)-1:0] o_word,
    output logic [$clog2(((pbp_pkg::PEND_W + MAX_CODE_BITS) + 7) / 8 + 1)-1:0] o_nbytes
);
    import pbp_pkg::*;

    localparam int ACC_W    = PEND_W + MAX_CODE_BITS;
    localparam int W        = 8 * ((ACC_W + 7) / 8);
    localparam int CNT_W    = $clog2(W / 8 + 1);
    localparam int TOT_W    = $clog2(ACC_W + 1);
    localparam int SH_W     = $clog2(W + 1);

    logic [PEND_W-1:0]       r_pend, n_pend;
    logic [PCNT_W-1:0]       r_pcnt, n_pcnt;
    logic [LEN_W-1:0]        len_sat;
    logic [ACC_W+CODE_W-1:0] code_wide;
    logic [ACC_W-1:0]        mask;
    logic [ACC_W-1:0]        acc;
    logic [TOT_W-1:0]        total;
    logic [PCNT_W-1:0]       rem;
    logic [PEND_W-1:0]       pmask;
    logic                    accept;

    always_comb begin
        len_sat   = (i_code_length > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                            : i_code_length;
        mask      = ~({ACC_W{1'b1}} << len_sat);
        code_wide = {{ACC_W{1'b0}}, i_code_value};
        acc       = (ACC_W'(r_pend) << len_sat) | (code_wide[ACC_W-1:0] & mask);
        total     = TOT_W'(r_pcnt) + TOT_W'(len_sat);
        rem       = total[PCNT_W-1:0];
        pmask     = ~({PEND_W{1'b1}} << rem);
        o_word    = W'(acc) << (SH_W'(W) - SH_W'(total));
        o_nbytes  = CNT_W'(total >> 3) + CNT_W'(i_flush && (rem != '0));
        o_ready   = !i_q_stat.full;
        accept    = i_valid && o_ready;
        o_push    = accept && (o_nbytes != '0);
        n_pend    = r_pend;
        n_pcnt    = r_pcnt;
        if (accept) begin
            n_pend = i_flush ? '0 : (acc[PEND_W-1:0] & pmask);
            n_pcnt = i_flush ? '0 : rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_pcnt <= '0;
        end else begin
            r_pend <= n_pend;
            r_pcnt <= n_pcnt;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/pbp_queue.sv
// Two-entry queue between the front end and the byte emitter.
`default_nettype none
module pbp_queue #(
    parameter int DATA_W = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wire [DATA_W-1:0]      i_data,
    input  wire                   i_pop,
    output logic [DATA_W-1:0]     o_data,
    output pbp_pkg::t_q_stat      o_stat
);
    import pbp_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              do_push, do_pop;

    always_comb begin
        o_stat.full  = (r_cnt == CNT_W'(Q_DEPTH));
        o_stat.empty = (r_cnt == '0);
        o_data       = r_mem[r_rptr];
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        n_wptr       = r_wptr;
        n_rptr       = r_rptr;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        n_cnt = r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(Q_DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("push into full queue");
endmodule
`default_nettype wire

FILE: rtl/core/pbp_back.sv
// Back end: emits the queued bytes one per cycle while the receiver is ready, top byte first.
`default_nettype none
module pbp_back #(
    parameter int W     = 40,
    parameter int CNT_W = 3
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_q_valid,
    input  wire [W-1:0]                i_q_word,
    input  wire [CNT_W-1:0]            i_q_nbytes,
    output logic                       o_pop,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [pbp_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last
);
    import pbp_pkg::*;

    logic [W-1:0]     r_word, n_word;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_busy, n_busy;
    logic             out_acc, take;

    always_comb begin
        o_valid    = r_busy;
        o_out_byte = r_word[W-1 -: BYTE_W];
        o_last     = (r_left == CNT_W'(1));
        out_acc    = r_busy && i_ready;
        take       = !r_busy || (out_acc && o_last);
        o_pop      = take && i_q_valid;
        n_word     = r_word;
        n_left     = r_left;
        n_busy     = r_busy;
        if (out_acc && !o_last) begin
            n_word = r_word << BYTE_W;
            n_left = r_left - 1'b1;
        end else if (take) begin
            n_busy = i_q_valid;
            if (i_q_valid) begin
                n_word = i_q_word;
                n_left = i_q_nbytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else begin
            r_busy <= n_busy;
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    a_busy_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != '0))
        else $error("emitter busy with no bytes left");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_ready) |=> (r_busy && $stable(r_left)))
        else $error("byte count moved during stall");
endmodule
`default_nettype wire

FILE: rtl/core/msb_first_bit_packer_unit.sv
// Top level of the MSB-first variable-length bit packer.
//
// Input channel (i_valid/o_ready): one code per item, i_code_value right
// aligned with i_code_length valid bits (0 to MAX_CODE_BITS, larger lengths
// saturate), i_flush pads the stream with zeros to the next byte boundary.
// Output channel (o_valid/i_ready): one packed byte per item, first stream
// bit in bit 7; o_last marks the last byte caused by one input code.
// A taken code's bytes are written into the queue, then loaded into the
// emitter's output register. Throughput: the emitter sends one byte a cycle
// while the receiver is ready; a 32-bit code completes up to 4 bytes plus one
// flush byte, and a code that completes no byte adds no queue entry.
// A two-entry queue sits between the front end and the emitter, so codes
// keep arriving while bytes drain; o_ready drops only when the queue is full.
// When the receiver stalls, the current byte holds and the queue fills.
// Reset clears the pending bits, the queue and the emitter.
`default_nettype none
module msb_first_bit_packer_unit #(
    parameter int MAX_CODE_BITS = 32
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire [pbp_pkg::CODE_W-1:0]  i_code_value,
    input  wire [pbp_pkg::LEN_W-1:0]   i_code_length,
    input  wire                        i_flush,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [pbp_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last
);
    import pbp_pkg::*;

    localparam int ACC_W = PEND_W + MAX_CODE_BITS;
    localparam int W     = 8 * ((ACC_W + 7) / 8);
    localparam int CNT_W = $clog2(W / 8 + 1);

    t_q_stat          q_stat;
    logic             push, pop;
    logic [W-1:0]     f_word;
    logic [CNT_W-1:0] f_nbytes;
    logic [W-1:0]     q_word;
    logic [CNT_W-1:0] q_nbytes;

    pbp_front #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_code_value (i_code_value),
        .i_code_length(i_code_length),
        .i_flush      (i_flush),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_word       (f_word),
        .o_nbytes     (f_nbytes)
    );

    pbp_queue #(.DATA_W(W + CNT_W)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_word, f_nbytes}),
        .i_pop  (pop),
        .o_data ({q_word, q_nbytes}),
        .o_stat (q_stat)
    );

    pbp_back #(.W(W), .CNT_W(CNT_W)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!q_stat.empty),
        .i_q_word  (q_word),
        .i_q_nbytes(q_nbytes),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out_byte(o_out_byte),
        .o_last    (o_last)
    );
endmodule
`default_nettype wire

FILE: verif/tb_msb_first_bit_packer_unit.sv
// Testbench of the MSB-first bit packer: directed rows, then random codes checked per byte.
`default_nettype none
module tb_msb_first_bit_packer_unit;
    import pbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 80;
    localparam int ITEMS_PER_PHASE = 50;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_out_byte;

    typedef struct packed {
        logic        typed;
        logic [2:0]  n;
        logic [39:0] bytes;
    } t_listed_bytes;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              flush;
        t_listed_bytes     ex;
    } t_code_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [CODE_W-1:0] i_code_value = '0;
    logic [LEN_W-1:0]  i_code_length = '0;
    logic              i_flush = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_last;

    logic [PEND_W-1:0] pend_bits = '0;
    logic [PCNT_W-1:0] pend_cnt = '0;

    t_out_byte     due_bytes[$];
    t_listed_bytes listed_q[$];
    t_code_row     code_rows[$];

    int err_cnt = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    msb_first_bit_packer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code_value  (i_code_value),
        .i_code_length (i_code_length),
        .i_flush       (i_flush),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic pack_code(input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len_in,
                             input logic flush, output int n, output logic [39:0] bytes);
        int                eff_len;
        int                total;
        logic [CODE_W-1:0] code_m;
        logic [38:0]       acc;
        logic [38:0]       sh;
        n = 0;
        bytes = '0;
        eff_len = (len_in > 6'd32) ? 32 : int'(len_in);
        code_m = (eff_len == 32) ? code : (code & ((32'd1 << eff_len) - 32'd1));
        acc = ({32'd0, pend_bits} << eff_len) | {7'd0, code_m};
        total = int'(pend_cnt) + eff_len;
        while (total >= 8) begin
            total -= 8;
            sh = acc >> total;
            bytes[39 - 8 * n -: 8] = sh[7:0];
            n++;
        end
        acc = acc & ((39'd1 << total) - 39'd1);
        if (flush && total > 0) begin
            sh = acc << (8 - total);
            bytes[39 - 8 * n -: 8] = sh[7:0];
            n++;
            acc = '0;
            total = 0;
        end
        pend_bits = acc[PEND_W-1:0];
        pend_cnt = total[PCNT_W-1:0];
    endtask

    always @(posedge i_clk) begin : track
        t_listed_bytes row;
        t_out_byte     ob;
        t_out_byte     want;
        int            n;
        logic [39:0]   bytes;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                row = listed_q.pop_front();
                pack_code(i_code_value, i_code_length, i_flush, n, bytes);
                if (row.typed) begin
                    n = int'(row.n);
                    bytes = row.bytes;
                end
                for (int k = 0; k < n; k++) begin
                    ob.data = bytes[39 - 8 * k -: 8];
                    ob.last = (k == n - 1);
                    due_bytes.push_back(ob);
                end
            end
            if (o_valid && i_ready) begin
                if (due_bytes.size() == 0) begin
                    $display("%0t: unexpected byte %02h last %0b", $time, o_out_byte, o_last);
                    err_cnt++;
                end else begin
                    want = due_bytes.pop_front();
                    if (o_out_byte !== want.data) begin
                        $display("%0t: out_byte mismatch, expected %02h got %02h",
                                 $time, want.data, o_out_byte);
                        err_cnt++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last mismatch, expected %0b got %0b",
                                 $time, want.last, o_last);
                        err_cnt++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, %0d bytes outstanding", $time, due_bytes.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic add_row(input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                           input logic flush, input logic typed, input logic [2:0] n,
                           input logic [39:0] bytes);
        t_code_row r;
        r.code = code;
        r.len = len;
        r.flush = flush;
        r.ex.typed = typed;
        r.ex.n = n;
        r.ex.bytes = bytes;
        code_rows.push_back(r);
    endtask

    task automatic send_code(input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                             input logic flush, input t_listed_bytes ex);
        listed_q.push_back(ex);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_code_value <= $urandom;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_code_value <= code;
        i_code_length <= len;
        i_flush <= flush;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        @(negedge i_clk);
    endtask

    task automatic drain_wait();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (due_bytes.size() != 0) @(negedge i_clk);
    endtask

    initial begin : stim
        t_listed_bytes none;
        logic [LEN_W-1:0] len;
        int r;
        none = '0;

        add_row(32'hFFFF_FFFF, 6'd32, 1'b0, 1'b1, 3'd4, 40'hFFFF_FFFF_00);
        add_row(32'h0000_0000, 6'd0,  1'b1, 1'b1, 3'd0, 40'h0);
        add_row(32'h0000_0005, 6'd3,  1'b0, 1'b1, 3'd0, 40'h0);
        add_row(32'h0000_0000, 6'd0,  1'b1, 1'b1, 3'd1, 40'hA0_0000_0000);
        add_row(32'hFFFF_FFFF, 6'd63, 1'b0, 1'b1, 3'd4, 40'hFFFF_FFFF_00);
        add_row(32'hFFFF_FFFF, 6'd1,  1'b1, 1'b1, 3'd1, 40'h80_0000_0000);
        add_row(32'hABCD_1234, 6'd8,  1'b0, 1'b1, 3'd1, 40'h34_0000_0000);
        add_row(32'hFFFF_FFFF, 6'd33, 1'b1, 1'b1, 3'd4, 40'hFFFF_FFFF_00);
        add_row(32'h0000_007F, 6'd7,  1'b0, 1'b0, 3'd0, 40'h0);
        add_row(32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, 3'd0, 40'h0);
        add_row(32'h0000_0001, 6'd1,  1'b0, 1'b0, 3'd0, 40'h0);
        add_row(32'h0000_0000, 6'd32, 1'b1, 1'b0, 3'd0, 40'h0);
        add_row(32'hAAAA_AAAA, 6'd31, 1'b0, 1'b0, 3'd0, 40'h0);
        add_row(32'h5555_5555, 6'd17, 1'b0, 1'b0, 3'd0, 40'h0);
        add_row(32'h1234_5678, 6'd20, 1'b0, 1'b0, 3'd0, 40'h0);
        add_row(32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0, 3'd0, 40'h0);
        add_row(32'hFFFF_FFFF, 6'd5,  1'b1, 1'b0, 3'd0, 40'h0);
        add_row(32'hDEAD_BEEF, 6'd12, 1'b0, 1'b0, 3'd0, 40'h0);
        add_row(32'hCAFE_F00D, 6'd32, 1'b1, 1'b0, 3'd0, 40'h0);
        add_row(32'h0000_0003, 6'd2,  1'b0, 1'b0, 3'd0, 40'h0);
        add_row(32'hFFFF_FFC0, 6'd6,  1'b0, 1'b0, 3'd0, 40'h0);
        add_row(32'h8000_0001, 6'd48, 1'b1, 1'b0, 3'd0, 40'h0);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < code_rows.size(); i++) begin
            send_code(code_rows[i].code, code_rows[i].len, code_rows[i].flush, code_rows[i].ex);
        end
        drain_wait();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == 0 && i == 10) begin
                    hold_reqs++;
                end
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    len = 6'd0;
                end else if (r < 12) begin
                    len = 6'($urandom_range(33, 63));
                end else if (r < 20) begin
                    len = 6'd32;
                end else begin
                    len = 6'($urandom_range(1, 31));
                end
                send_code($urandom, len, ($urandom_range(0, 99) < 15), none);
            end
            drain_wait();
        end

        recv_stall_pct = 0;
        repeat (20) @(negedge i_clk);
        if (err_cnt == 0 && due_bytes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
rtl/core/pbp_pkg.sv
rtl/core/pbp_front.sv
rtl/core/pbp_queue.sv
rtl/core/pbp_back.sv
rtl/core/msb_first_bit_packer_unit.sv
verif/tb_msb_first_bit_packer_unit.sv
